@@ rtl/core/cssw_pkg.sv @@
// Shared constants, types and fixed-point tables for the cosine-sum window generator.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
`default_nettype none

package cssw_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned MAX_TERMS  = 5;
  localparam int unsigned LANES      = MAX_TERMS - 1;   // term 0 is cos(0), no lane

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned SPAN_W = 13;
  localparam int unsigned TERM_W = 3;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned COS_W  = 18;
  localparam int unsigned PROD_W = COEF_W + COS_W;
  localparam int unsigned SUM_W  = PROD_W + 3;
  localparam int unsigned TURN_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam int unsigned DIV_BITS   = 3;                // quotient bits per stage
  localparam int unsigned DIV_STAGES = TURN_W / DIV_BITS;
  localparam int unsigned POLY_STEPS = 5;
  localparam int unsigned LANE_LAT   = 3 + 2 * POLY_STEPS + 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR     = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [COS_W-1:0]  cos_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // flags that ride along with each transaction
  typedef struct packed {
    logic valid;
    logic err;
    logic single;
  } side_t;

  // window geometry derived from the configuration registers
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [SPAN_W-1:0] span;
    logic              single;
  } geom_t;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // floor(a/d) = (a * ceil(2^(30+l)/d)) >> (30+l), exact for a < 2^30
  localparam logic [30:0] RCP_90  = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam logic [30:0] RCP_56  = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [30:0] RCP_30  = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [30:0] RCP_12  = 31'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [30:0] RCP_2   = 31'(((64'd1 << 31) + 64'd1) / 64'd2);
  localparam logic [30:0] RCP_110 = 31'(((64'd1 << 37) + 64'd109) / 64'd110);
  localparam logic [30:0] RCP_72  = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [30:0] RCP_42  = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] RCP_20  = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] RCP_6   = 31'(((64'd1 << 33) + 64'd5) / 64'd6);

  localparam logic [30:0] RCP_COS [POLY_STEPS] = '{RCP_90, RCP_56, RCP_30, RCP_12, RCP_2};
  localparam logic [30:0] RCP_SIN [POLY_STEPS] = '{RCP_110, RCP_72, RCP_42, RCP_20, RCP_6};
  localparam logic [5:0]  SHF_COS [POLY_STEPS] = '{6'd37, 6'd36, 6'd35, 6'd34, 6'd31};
  localparam logic [5:0]  SHF_SIN [POLY_STEPS] = '{6'd37, 6'd37, 6'd36, 6'd35, 6'd33};

endpackage

`default_nettype wire

@@ rtl/core/cssw_if.sv @@
// Valid/ready channel interfaces for sample indexes and window weights.
// Depends on cssw_pkg for field widths.
`default_nettype none

interface cssw_in_if;
  logic                          valid;
  logic                          ready;
  logic [cssw_pkg::IDX_W-1:0]    sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface cssw_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [cssw_pkg::COS_W-1:0] weight;
  logic                          index_error;
  modport source (output valid, output weight, output index_error, input ready);
  modport sink   (input valid, input weight, input index_error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cssw_phase.sv @@
// Phase front end: range check, pipelined restoring divider n/span and turn
// quantization for cosine terms 1..4. Depends on cssw_pkg.
`default_nettype none

module cssw_phase (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [cssw_pkg::IDX_W-1:0]      sample_index,
  input  cssw_pkg::geom_t                 geom,
  output cssw_pkg::side_t                 side_o,
  output logic [cssw_pkg::TURN_W-1:0]     turn_o [cssw_pkg::LANES]
);

  localparam int unsigned DS = cssw_pkg::DIV_STAGES;
  localparam int unsigned SW = cssw_pkg::SPAN_W;
  localparam int unsigned TW = cssw_pkg::TURN_W;

  logic [SW:0]            two_span;
  logic [SW:0]            p_sum;
  logic [SW:0]            p_red;
  cssw_pkg::side_t        side_nxt;

  logic [SW:0]            pr0_r;
  logic [SW-1:0]          rem_r  [DS+1];
  logic [TW-1:0]          quo_r  [DS+1];
  cssw_pkg::side_t        side_r [DS+1];

  // p = 2n + span, reduced mod 2*span
  always_comb begin
    two_span        = {geom.span, 1'b0};
    p_sum           = (SW+1)'({sample_index, 1'b0}) + (SW+1)'(geom.span);
    p_red           = (p_sum >= two_span) ? p_sum - two_span : p_sum;
    side_nxt.valid  = in_valid;
    side_nxt.err    = {1'b0, sample_index} >= geom.len;
    side_nxt.single = geom.single;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
    end else if (adv) begin
      side_r[0] <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr0_r    <= p_red;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
    end
  end

  // quotient of p_red * 2^23 / span, DIV_BITS bits per stage
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [SW:0]   t_c;
    logic          bit_c;
    logic [SW-1:0] rem_c;
    logic [TW-1:0] quo_c;

    always_comb begin
      rem_c = rem_r[j];
      quo_c = quo_r[j];
      t_c   = '0;
      bit_c = 1'b0;
      for (int i = 0; i < cssw_pkg::DIV_BITS; i++) begin
        t_c   = (j == 0 && i == 0) ? pr0_r : {rem_c, 1'b0};
        bit_c = t_c >= {1'b0, geom.span};
        if (bit_c) begin
          t_c = t_c - {1'b0, geom.span};
        end
        rem_c = t_c[SW-1:0];
        quo_c = {quo_c[TW-2:0], bit_c};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j+1] <= '0;
      end else if (adv) begin
        side_r[j+1] <= side_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= rem_c;
        quo_r[j+1] <= quo_c;
      end
    end
  end

  // u_k = k*Q + floor((2kR + span) / (2 span)), the carry is 0..4
  logic [16:0]    twos;
  logic [16:0]    tk_c    [cssw_pkg::LANES];
  logic [2:0]     carry_c [cssw_pkg::LANES];
  logic [TW-1:0]  turn_c  [cssw_pkg::LANES];
  logic [TW-1:0]  turn_r  [cssw_pkg::LANES];
  cssw_pkg::side_t side_out_r;

  always_comb begin
    twos = 17'({geom.span, 1'b0});
    for (int k = 0; k < cssw_pkg::LANES; k++) begin
      tk_c[k]    = 17'(rem_r[DS]) * 17'(2 * (k + 1)) + 17'(geom.span);
      carry_c[k] = 3'(tk_c[k] >= twos) + 3'(tk_c[k] >= 17'(twos * 2))
                 + 3'(tk_c[k] >= 17'(twos * 3)) + 3'(tk_c[k] >= 17'(twos * 4));
      turn_c[k]  = quo_r[DS] * TW'(k + 1) + TW'(carry_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_out_r <= '0;
    end else if (adv) begin
      side_out_r <= side_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      turn_r <= turn_c;
    end
  end

  assign side_o = side_out_r;
  assign turn_o = turn_r;

endmodule

`default_nettype wire

@@ rtl/core/cssw_cos.sv @@
// One cosine lane: 24-bit turn to Q16 cosine via octant folding and a
// pipelined Taylor evaluation in Q30. Depends on cssw_pkg.
`default_nettype none

module cssw_cos (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [cssw_pkg::TURN_W-1:0]  turn,
  output cssw_pkg::cos_t               cos_o
);

  localparam int unsigned PS = cssw_pkg::POLY_STEPS;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        sw;
  } ctx_t;

  logic        fold_c;
  logic [22:0] vdiff_c;
  logic [21:0] v_c;

  logic [53:0] prod1_r;
  logic [1:0]  quad1_r;
  logic        sw1_r;
  logic [29:0] xs2_r;
  logic [1:0]  quad2_r;
  logic        sw2_r;
  logic [59:0] sq_r;
  logic [29:0] xs3_r;
  logic [1:0]  quad3_r;
  logic        sw3_r;
  ctx_t        ctx0_c;

  logic [60:0] m_r    [PS];
  ctx_t        ctxm_r [PS];
  logic [60:0] d_r    [PS];
  ctx_t        ctxd_r [PS];
  logic [30:0] t_c    [PS];

  // fold to [0, 1/8 turn]; past the midpoint cos and sin swap
  always_comb begin
    fold_c  = turn[21:0] > 22'h200000;
    vdiff_c = 23'h400000 - {1'b0, turn[21:0]};
    v_c     = fold_c ? vdiff_c[21:0] : turn[21:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= 54'(v_c) * 54'(cssw_pkg::PI_Q30);
      quad1_r <= turn[23:22];
      sw1_r   <= turn[22] ^ fold_c;
      xs2_r   <= 30'((prod1_r + 54'(1 << 22)) >> 23);
      quad2_r <= quad1_r;
      sw2_r   <= sw1_r;
      sq_r    <= 60'(xs2_r) * 60'(xs2_r);
      xs3_r   <= xs2_r;
      quad3_r <= quad2_r;
      sw3_r   <= sw2_r;
    end
  end

  always_comb begin
    ctx0_c.x    = xs3_r;
    ctx0_c.x2   = sq_r[59:30];
    ctx0_c.quad = quad3_r;
    ctx0_c.sw   = sw3_r;
  end

  // t_i = ONE - mul(x2, t_{i-1}) / d_i, t_0 = ONE
  for (genvar i = 0; i < PS; i++) begin : g_step
    ctx_t        ctx_src;
    logic [30:0] t_prev;
    logic [30:0] rcp;

    if (i == 0) begin : g_first
      assign ctx_src = ctx0_c;
      assign t_prev  = cssw_pkg::Q30_ONE;
    end else begin : g_next
      assign ctx_src = ctxd_r[i-1];
      assign t_prev  = t_c[i-1];
    end

    assign rcp = ctxm_r[i].sw ? cssw_pkg::RCP_SIN[i] : cssw_pkg::RCP_COS[i];

    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[i]    <= 61'(ctx_src.x2) * 61'(t_prev);
        ctxm_r[i] <= ctx_src;
        d_r[i]    <= 61'(m_r[i][59:30]) * 61'(rcp);
        ctxd_r[i] <= ctxm_r[i];
      end
    end

    assign t_c[i] = cssw_pkg::Q30_ONE - (ctxd_r[i].sw ? 31'(d_r[i] >> cssw_pkg::SHF_SIN[i])
                                                      : 31'(d_r[i] >> cssw_pkg::SHF_COS[i]));
  end

  // sin needs the final multiply by x; cos multiplies by one
  logic [30:0] xs_c;
  logic [61:0] f_r;
  logic [1:0]  quadf_r;
  logic [31:0] rnd_c;
  logic [16:0] mag_c;
  cssw_pkg::cos_t cos_r;

  assign xs_c = ctxd_r[PS-1].sw ? {1'b0, ctxd_r[PS-1].x} : cssw_pkg::Q30_ONE;

  always_comb begin
    rnd_c = 32'(f_r[60:30]) + 32'd8192;
    mag_c = 17'(rnd_c >> 14);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r     <= 62'(xs_c) * 62'(t_c[PS-1]);
      quadf_r <= ctxd_r[PS-1].quad;
      cos_r   <= (quadf_r == 2'd1 || quadf_r == 2'd2) ? -cssw_pkg::cos_t'(mag_c)
                                                      : cssw_pkg::cos_t'(mag_c);
    end
  end

  assign cos_o = cos_r;

endmodule

`default_nettype wire

@@ rtl/core/cssw_acc.sv @@
// Weighted sum of cosine terms, rounding, saturation, error and single-point overrides and result register.
// Depends on cssw_pkg.
`default_nettype none

module cssw_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  cssw_pkg::side_t               side_i,
  input  cssw_pkg::cos_t                cos_i   [cssw_pkg::LANES],
  input  cssw_pkg::coef_t               coef_i  [cssw_pkg::MAX_TERMS],
  input  logic [cssw_pkg::MAX_TERMS-1:0] term_en,
  output logic                          valid_o,
  output cssw_pkg::coef_t               weight_o,
  output logic                          error_o
);

  localparam int unsigned NT = cssw_pkg::MAX_TERMS;

  cssw_pkg::prod_t prod_c [NT];
  cssw_pkg::prod_t prod_r [NT];
  cssw_pkg::sum_t  sum_c;
  cssw_pkg::sum_t  sum_r;
  cssw_pkg::sum_t  rnd_c;
  cssw_pkg::coef_t wt_c;
  cssw_pkg::side_t side1_r;
  cssw_pkg::side_t side2_r;
  logic            valid_r;
  cssw_pkg::coef_t weight_r;
  logic            error_r;

  always_comb begin
    // term 0 has cos = 1.0
    prod_c[0] = term_en[0] ? (cssw_pkg::prod_t'(coef_i[0]) <<< 16) : '0;
    for (int k = 1; k < NT; k++) begin
      prod_c[k] = term_en[k] ? cssw_pkg::prod_t'(coef_i[k]) * cssw_pkg::prod_t'(cos_i[k-1])
                             : '0;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < NT; k++) begin
      sum_c = sum_c + cssw_pkg::sum_t'(prod_r[k]);
    end
  end

  always_comb begin
    rnd_c = (sum_r + cssw_pkg::sum_t'(32768)) >>> 16;
    if (side2_r.err) begin
      wt_c = '0;
    end else if (side2_r.single) begin
      wt_c = cssw_pkg::coef_t'(65536);
    end else if (rnd_c > cssw_pkg::sum_t'(131071)) begin
      wt_c = cssw_pkg::coef_t'(131071);
    end else if (rnd_c < -cssw_pkg::sum_t'(131072)) begin
      wt_c = cssw_pkg::coef_t'(-131072);
    end else begin
      wt_c = cssw_pkg::coef_t'(rnd_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      side1_r <= side_i;
      side2_r <= side1_r;
      valid_r <= side2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod_c;
      sum_r    <= sum_c;
      weight_r <= wt_c;
      error_r  <= side2_r.err;
    end
  end

  assign valid_o  = valid_r;
  assign weight_o = weight_r;
  assign error_o  = error_r;

endmodule

`default_nettype wire

@@ rtl/core/cosine_sum_window_generator.sv @@
// Cosine-sum window generator top level: configuration registers, stall
// control and the phase / cosine / accumulate pipeline.
// Depends on cssw_pkg, cssw_if, cssw_phase, cssw_cos and cssw_acc.
//
// Usage:
//  - in_if carries a sample index n; out_if returns one transaction per
//    input: weight w[n] (Q2.16, saturated) and index_error (n >= N, weight 0).
//  - Configuration: cfg_wr_en/cfg_index/cfg_wdata write window_length,
//    symmetric, term_count and coefficients a0..a4. Write only while idle.
//  - Throughput: one transaction per clock, sustained unless the output stalls.
//  - Pipeline: an accepted input passes the range check and phase divider,
//    then the cosine lanes, then multiply, sum and round before it reaches
//    out_if.valid. The divider depth sets most of the front end; the Q30
//    series evaluation sets the lane depth.
//  - Stall: the whole pipeline holds while out_if.valid is high and
//    out_if.ready is low; in_if.ready drops in that same cycle.
//  - Reset (rst_n low, synchronous): pipeline empties, registers return to
//    N=64, symmetric, two terms, a0=a1=0.5 (Hann).
`default_nettype none

module cosine_sum_window_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  cssw_in_if.sink                             in_if,
  cssw_out_if.source                          out_if,
  input  logic                                cfg_wr_en,
  input  logic [cssw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cssw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned LAT = cssw_pkg::LANE_LAT;
  localparam int unsigned NT  = cssw_pkg::MAX_TERMS;

  // configuration registers
  logic [cssw_pkg::LEN_W-1:0]  len_r;
  logic                        sym_r;
  logic [cssw_pkg::TERM_W-1:0] terms_r;
  cssw_pkg::coef_t             coef_r [NT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= 13'd64;
      sym_r     <= 1'b1;
      terms_r   <= 3'd2;
      coef_r[0] <= 18'sd32768;
      coef_r[1] <= 18'sd32768;
      coef_r[2] <= '0;
      coef_r[3] <= '0;
      coef_r[4] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cssw_pkg::REG_WINDOW_LENGTH: len_r     <= cfg_wdata[cssw_pkg::LEN_W-1:0];
        cssw_pkg::REG_SYMMETRIC:     sym_r     <= cfg_wdata[0];
        cssw_pkg::REG_TERM_COUNT:    terms_r   <= cfg_wdata[cssw_pkg::TERM_W-1:0];
        cssw_pkg::REG_COEF_ZERO:     coef_r[0] <= cssw_pkg::coef_t'(cfg_wdata);
        cssw_pkg::REG_COEF_ONE:      coef_r[1] <= cssw_pkg::coef_t'(cfg_wdata);
        cssw_pkg::REG_COEF_TWO:      coef_r[2] <= cssw_pkg::coef_t'(cfg_wdata);
        cssw_pkg::REG_COEF_THREE:    coef_r[3] <= cssw_pkg::coef_t'(cfg_wdata);
        cssw_pkg::REG_COEF_FOUR:     coef_r[4] <= cssw_pkg::coef_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // geometry: clamp N, span = N-1 if symmetric else N, single-point window, term enables
  cssw_pkg::geom_t             geom;
  logic [cssw_pkg::LEN_W-1:0]  len_eff;
  logic [cssw_pkg::TERM_W-1:0] terms_eff;
  logic [NT-1:0]               term_en;

  always_comb begin
    len_eff     = (len_r > cssw_pkg::LEN_W'(cssw_pkg::MAX_LENGTH))
                ? cssw_pkg::LEN_W'(cssw_pkg::MAX_LENGTH) : len_r;
    geom.len    = len_eff;
    geom.span   = sym_r ? len_eff - 13'd1 : len_eff;
    geom.single = sym_r && (len_eff == 13'd1);
    if (terms_r == '0) begin
      terms_eff = 3'd1;
    end else if (terms_r > cssw_pkg::TERM_W'(NT)) begin
      terms_eff = cssw_pkg::TERM_W'(NT);
    end else begin
      terms_eff = terms_r;
    end
    for (int k = 0; k < NT; k++) begin
      term_en[k] = cssw_pkg::TERM_W'(k) < terms_eff;
    end
  end

  // global advance: the whole pipe moves unless the result register is stuck
  logic adv;
  logic acc_valid;

  assign adv         = !acc_valid || out_if.ready;
  assign in_if.ready = adv;

  cssw_pkg::side_t                   side_ph;
  logic [cssw_pkg::TURN_W-1:0]       turn [cssw_pkg::LANES];
  cssw_pkg::cos_t                    cos_v [cssw_pkg::LANES];

  cssw_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_if.valid),
    .sample_index (in_if.sample_index),
    .geom         (geom),
    .side_o       (side_ph),
    .turn_o       (turn)
  );

  for (genvar l = 0; l < cssw_pkg::LANES; l++) begin : g_lane
    cssw_cos u_cos (
      .clk   (clk),
      .adv   (adv),
      .turn  (turn[l]),
      .cos_o (cos_v[l])
    );
  end

  // flags follow the lanes stage for stage
  cssw_pkg::side_t side_dly_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) begin
        side_dly_r[s] <= '0;
      end
    end else if (adv) begin
      side_dly_r[0] <= side_ph;
      for (int s = 1; s < LAT; s++) begin
        side_dly_r[s] <= side_dly_r[s-1];
      end
    end
  end

  cssw_pkg::coef_t acc_weight;
  logic            acc_error;

  cssw_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .side_i   (side_dly_r[LAT-1]),
    .cos_i    (cos_v),
    .coef_i   (coef_r),
    .term_en  (term_en),
    .valid_o  (acc_valid),
    .weight_o (acc_weight),
    .error_o  (acc_error)
  );

  assign out_if.valid       = acc_valid;
  assign out_if.weight      = acc_weight;
  assign out_if.index_error = acc_error;

  // out-of-range index always reports a zero weight
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.index_error |-> out_if.weight == '0)
    else $error("index error with nonzero weight");

  // a stuck result register must stop input acceptance
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input accepted during output stall");

  // flag pipe holds while stalled
  a_side_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(side_dly_r[LAT-1]))
    else $error("flag pipe moved during stall");

endmodule

`default_nettype wire
